>>> src/ffbsa_pkg.sv
// ============================================================================
// ffbsa_pkg
// Shared sizes, codes, types and helpers of the first-fit block suballocator.
// ============================================================================
package ffbsa_pkg;

    localparam int MAX_BLOCKS = 8;
    localparam int MAX_RANGES = 16;
    localparam int SIZE_BITS  = 40;

    // fixed field widths
    localparam int TYPE_W   = 5;
    localparam int ALOG_W   = 5;
    localparam int FBLK_W   = 3;
    localparam int STATUS_W = 2;
    localparam int OBLK_W   = 3;
    localparam int AMASK_W  = 31;

    localparam int BLK_W    = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int BLK_CW   = $clog2(MAX_BLOCKS + 1);
    localparam int NUM_ROWS = MAX_BLOCKS + 2;
    localparam int ROW_W    = $clog2(NUM_ROWS);
    localparam int STRIDE   = MAX_RANGES + 1;
    localparam int SLOT_W   = $clog2(STRIDE);
    localparam int CNT_W    = $clog2(MAX_RANGES + 1);
    localparam int OCNT_W   = $clog2(MAX_RANGES + 2);
    localparam int RAM_DEPTH = NUM_ROWS * STRIDE;
    localparam int ADDR_W   = $clog2(RAM_DEPTH);

    // range starts may run one bit past the size width
    localparam int START_W  = SIZE_BITS + 1;
    localparam int END_W    = START_W + 1;
    localparam int AL_W     = ((START_W > AMASK_W) ? START_W : AMASK_W) + 1;
    localparam int ASZ_W    = AL_W + 1;
    localparam int ENT_W    = START_W + SIZE_BITS;

    localparam logic [SIZE_BITS-1:0] DFLT_RESET = SIZE_BITS'(64'd268435456);

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_BLOCK  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_LIST_FULL = 2'd2;

    typedef logic [ROW_W-1:0]     t_row;
    typedef logic [ADDR_W-1:0]    t_addr;
    typedef logic [START_W-1:0]   t_start;
    typedef logic [SIZE_BITS-1:0] t_len;

    function automatic t_len sat_add(input t_len a, input t_len b);
        logic [SIZE_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SIZE_BITS] ? {SIZE_BITS{1'b1}} : s[SIZE_BITS-1:0];
    endfunction

    function automatic t_addr slot_addr(input t_row row, input logic [SLOT_W-1:0] idx);
        return ADDR_W'(row) * ADDR_W'(STRIDE) + ADDR_W'(idx);
    endfunction

endpackage

>>> src/ffbsa_ram.sv
// ============================================================================
// ffbsa_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module ffbsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic                                       i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/first_fit_block_suballocator_top.sv
// ============================================================================
// first_fit_block_suballocator_top
// First-fit suballocator over up to MAX_BLOCKS blocks with free-range merging.
// ============================================================================
// One request word in, one result word out. An allocate scans the used blocks
// of matching memory type and linear flag in index order and takes the first
// free range that still holds the request once its start is rounded up to the
// alignment; a miss claims the lowest unused block of max(default size,
// request). A free inserts its range in offset order and merges it with the
// next and then the previous range. All free-range lists live in one RAM with
// one row per block plus two spare rows: every edit of a used block's list
// streams the old row into a spare row (a first pass drops an allocate's hit
// range and adds its alignment gap or the freed range, a second pass adds an
// allocate's remainder), and the edit is committed by swapping row pointers,
// so an edit that would overflow a list simply drops the spare row and leaves
// the block untouched. Timing is set by the RAM's single read port: an allocate
// visits the blocks in turn and reads, aligns and fit-compares each scanned
// range, then runs one or two rewrite passes, each copying the kept entries
// and putting in any new range; a free is one pass. A new request word is
// taken whenever the sequencer is idle, even while the previous result word
// still waits at the output register. No clearing pass is needed after reset:
// per-block counts start at zero.
// ============================================================================
module first_fit_block_suballocator_top
    import ffbsa_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // request channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_mode,
    input  logic [TYPE_W-1:0]     i_memory_type,
    input  logic                  i_linear,
    input  logic [SIZE_BITS-1:0]  i_req_size,
    input  logic [ALOG_W-1:0]     i_align_log2,
    input  logic [FBLK_W-1:0]     i_free_block,
    input  logic [SIZE_BITS-1:0]  i_free_offset,
    // configuration channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [SIZE_BITS-1:0]  i_cfg_data,
    // result channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [STATUS_W-1:0]   o_status,
    output logic [OBLK_W-1:0]     o_grant_block,
    output logic [SIZE_BITS-1:0]  o_grant_offset,
    output logic                  o_new_block
);

    localparam logic [4:0] S_IDLE      = 5'd0;
    localparam logic [4:0] S_SC_BLK    = 5'd1;
    localparam logic [4:0] S_SC_RD     = 5'd2;
    localparam logic [4:0] S_SC_GET    = 5'd3;
    localparam logic [4:0] S_SC_CMP    = 5'd4;
    localparam logic [4:0] S_HIT       = 5'd5;
    localparam logic [4:0] S_NEW_FIND  = 5'd6;
    localparam logic [4:0] S_NEW_SZ    = 5'd7;
    localparam logic [4:0] S_NEW_WR    = 5'd8;
    localparam logic [4:0] S_PS_INIT   = 5'd9;
    localparam logic [4:0] S_PS_RD     = 5'd10;
    localparam logic [4:0] S_PS_GET    = 5'd11;
    localparam logic [4:0] S_PS_NMRG   = 5'd12;
    localparam logic [4:0] S_PS_NCHK   = 5'd13;
    localparam logic [4:0] S_PS_NEMIT  = 5'd14;
    localparam logic [4:0] S_PS_EMIT_E = 5'd15;
    localparam logic [4:0] S_PS_FLUSH  = 5'd16;
    localparam logic [4:0] S_PS_END    = 5'd17;
    localparam logic [4:0] S_FIN       = 5'd18;

    // ---- control state (reset) ----
    logic [4:0]           r_state, n_state;
    logic [SIZE_BITS-1:0] r_dflt, n_dflt;
    logic                 r_used [MAX_BLOCKS];
    logic                 n_used [MAX_BLOCKS];
    logic [CNT_W-1:0]     r_cnt  [MAX_BLOCKS];
    logic [CNT_W-1:0]     n_cnt  [MAX_BLOCKS];
    t_row                 r_ptr  [MAX_BLOCKS];
    t_row                 n_ptr  [MAX_BLOCKS];
    t_row                 r_sp0, n_sp0, r_sp1, n_sp1;
    logic                 r_ov, n_ov;

    // ---- block attributes (written on claim) ----
    logic [TYPE_W-1:0]    r_type [MAX_BLOCKS];
    logic [TYPE_W-1:0]    n_type [MAX_BLOCKS];
    logic                 r_blin [MAX_BLOCKS];
    logic                 n_blin [MAX_BLOCKS];

    // ---- request ----
    logic                 r_mode, n_mode;
    logic [TYPE_W-1:0]    r_mtype, n_mtype;
    logic                 r_lreq, n_lreq;
    t_len                 r_size, n_size;
    logic [AMASK_W-1:0]   r_amask, n_amask;
    logic [BLK_CW-1:0]    r_blk, n_blk;
    logic [OCNT_W-1:0]    r_ri, n_ri;

    // ---- scan datapath ----
    t_start               r_off, n_off;
    logic [AL_W-1:0]      r_al, n_al;
    logic [END_W-1:0]     r_end, n_end;
    logic [ASZ_W-1:0]     r_asz, n_asz;

    // ---- hit bookkeeping ----
    t_len                 r_grant, n_grant;
    logic                 r_rem_en, n_rem_en;
    t_start               r_rem_s, n_rem_s;
    t_len                 r_rem_l, n_rem_l;

    // ---- rewrite pass ----
    t_row                 r_src, n_src, r_dst, n_dst;
    logic [OCNT_W-1:0]    r_n, n_n, r_skip, n_skip, r_i, n_i, r_o, n_o;
    logic                 r_skip_en, n_skip_en;
    logic                 r_ins, n_ins;
    t_start               r_ns, n_ns;
    t_len                 r_nl, n_nl;
    logic [END_W-1:0]     r_nend, n_nend;
    t_start               r_es, n_es;
    t_len                 r_el, n_el;
    logic                 r_mnext, n_mnext, r_econs, n_econs, r_atend, n_atend;
    logic                 r_hv, n_hv, r_pmerge, n_pmerge, r_pass2, n_pass2;
    t_start               r_hs, n_hs;
    t_len                 r_hl, n_hl;

    // ---- new block ----
    t_len                 r_bsz, n_bsz;

    // ---- result staging and output register ----
    logic [STATUS_W-1:0]  r_rs_status, n_rs_status;
    logic [BLK_W-1:0]     r_rs_blk, n_rs_blk;
    t_len                 r_rs_grant, n_rs_grant;
    logic                 r_rs_new, n_rs_new;
    logic [STATUS_W-1:0]  r_o_status, n_o_status;
    logic [OBLK_W-1:0]    r_o_blk, n_o_blk;
    t_len                 r_o_grant, n_o_grant;
    logic                 r_o_new, n_o_new;

    // ---- RAM ----
    logic                 ram_we, ram_re;
    t_addr                ram_waddr, ram_raddr;
    logic [ENT_W-1:0]     ram_wdata, ram_rdata;
    t_start               rd_s;
    t_len                 rd_l;

    logic [BLK_W-1:0]     bi;
    logic [BLK_W-1:0]     fb_idx;
    logic                 in_acc;
    logic                 free_hit;
    logic                 nf_found;
    logic [BLK_W-1:0]     nf_idx;
    logic [ASZ_W-1:0]     cmp_asz;
    logic [AL_W-1:0]      al_mask;

    ffbsa_ram #(
        .WIDTH (ENT_W),
        .DEPTH (RAM_DEPTH)
    ) u_ranges (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_s   = ram_rdata[ENT_W-1 -: START_W];
    assign rd_l   = ram_rdata[SIZE_BITS-1:0];
    assign bi     = r_blk[BLK_W-1:0];
    assign fb_idx = BLK_W'(i_free_block);
    assign in_acc = i_in_valid && !o_in_stall;
    assign free_hit = (32'(i_free_block) < 32'(MAX_BLOCKS)) && r_used[fb_idx];
    assign al_mask  = AL_W'(r_amask);
    assign cmp_asz  = ASZ_W'(r_al) + ASZ_W'(r_size);

    // lowest unused block
    always_comb begin
        nf_found = 1'b0;
        nf_idx   = '0;
        for (int k = MAX_BLOCKS - 1; k >= 0; k--) begin
            if (!r_used[k]) begin
                nf_found = 1'b1;
                nf_idx   = BLK_W'(k);
            end
        end
    end

    always_comb begin
        n_state = r_state;   n_dflt = r_dflt;
        n_used  = r_used;    n_cnt  = r_cnt;   n_ptr = r_ptr;
        n_sp0   = r_sp0;     n_sp1  = r_sp1;
        n_type  = r_type;    n_blin = r_blin;
        n_mode  = r_mode;    n_mtype = r_mtype; n_lreq = r_lreq;
        n_size  = r_size;    n_amask = r_amask; n_blk = r_blk; n_ri = r_ri;
        n_off   = r_off;     n_al = r_al;      n_end = r_end;  n_asz = r_asz;
        n_grant = r_grant;   n_rem_en = r_rem_en; n_rem_s = r_rem_s; n_rem_l = r_rem_l;
        n_src   = r_src;     n_dst = r_dst;    n_n = r_n;      n_skip = r_skip;
        n_i     = r_i;       n_o = r_o;        n_skip_en = r_skip_en;
        n_ins   = r_ins;     n_ns = r_ns;      n_nl = r_nl;    n_nend = r_nend;
        n_es    = r_es;      n_el = r_el;      n_mnext = r_mnext;
        n_econs = r_econs;   n_atend = r_atend; n_hv = r_hv;   n_pmerge = r_pmerge;
        n_pass2 = r_pass2;   n_hs = r_hs;      n_hl = r_hl;    n_bsz = r_bsz;
        n_rs_status = r_rs_status; n_rs_blk = r_rs_blk;
        n_rs_grant  = r_rs_grant;  n_rs_new = r_rs_new;
        n_o_status  = r_o_status;  n_o_blk  = r_o_blk;
        n_o_grant   = r_o_grant;   n_o_new  = r_o_new;
        // drop the output word once taken
        n_ov = r_ov && i_out_stall;

        ram_we = 1'b0; ram_waddr = '0; ram_wdata = '0;
        ram_re = 1'b0; ram_raddr = '0;

        if (i_cfg_valid) begin
            n_dflt = i_cfg_data;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_mode  = i_mode;
                    n_mtype = i_memory_type;
                    n_lreq  = i_linear;
                    n_size  = i_req_size;
                    n_amask = AMASK_W'((32'd1 << i_align_log2) - 32'd1);
                    n_rem_en = 1'b0;
                    n_pass2  = 1'b0;
                    n_rs_status = STATUS_OK;
                    n_rs_blk    = '0;
                    n_rs_grant  = '0;
                    n_rs_new    = 1'b0;
                    if (i_mode == MODE_FREE) begin
                        if (free_hit) begin
                            n_blk     = BLK_CW'(fb_idx);
                            n_src     = r_ptr[fb_idx];
                            n_dst     = r_sp0;
                            n_n       = OCNT_W'(r_cnt[fb_idx]);
                            n_skip_en = 1'b0;
                            n_skip    = '0;
                            n_ins     = 1'b1;
                            n_ns      = START_W'(i_free_offset);
                            n_nl      = i_req_size;
                            n_state   = S_PS_INIT;
                        end else begin
                            n_state = S_FIN;
                        end
                    end else begin
                        n_blk   = '0;
                        n_state = S_SC_BLK;
                    end
                end
            end

            S_SC_BLK: begin
                if (r_blk == BLK_CW'(MAX_BLOCKS)) begin
                    n_state = S_NEW_FIND;
                end else if (r_used[bi] && r_type[bi] == r_mtype && r_blin[bi] == r_lreq
                             && r_cnt[bi] != '0) begin
                    n_ri    = '0;
                    n_state = S_SC_RD;
                end else begin
                    n_blk = r_blk + 1'b1;
                end
            end

            S_SC_RD: begin
                ram_re    = 1'b1;
                ram_raddr = slot_addr(r_ptr[bi], r_ri[SLOT_W-1:0]);
                n_state   = S_SC_GET;
            end

            S_SC_GET: begin
                // round the start up to the alignment
                n_off   = rd_s;
                n_al    = (AL_W'(rd_s) + al_mask) & ~al_mask;
                n_end   = END_W'(rd_s) + END_W'(rd_l);
                n_state = S_SC_CMP;
            end

            S_SC_CMP: begin
                if (cmp_asz <= ASZ_W'(r_end)) begin
                    n_asz   = cmp_asz;
                    n_state = S_HIT;
                end else if (r_ri + 1'b1 == OCNT_W'(r_cnt[bi])) begin
                    n_blk   = r_blk + 1'b1;
                    n_state = S_SC_BLK;
                end else begin
                    n_ri    = r_ri + 1'b1;
                    n_state = S_SC_RD;
                end
            end

            S_HIT: begin
                // drop the hit range, put back the gap, later the remainder
                n_grant   = r_al[SIZE_BITS-1:0];
                n_rem_en  = (r_asz != ASZ_W'(r_end));
                n_rem_s   = r_asz[START_W-1:0];
                n_rem_l   = SIZE_BITS'(ASZ_W'(r_end) - r_asz);
                n_src     = r_ptr[bi];
                n_dst     = r_sp0;
                n_n       = OCNT_W'(r_cnt[bi]);
                n_skip_en = 1'b1;
                n_skip    = r_ri;
                n_ins     = (r_al != AL_W'(r_off));
                n_ns      = r_off;
                n_nl      = SIZE_BITS'(r_al - AL_W'(r_off));
                n_state   = S_PS_INIT;
            end

            S_PS_INIT: begin
                n_nend  = END_W'(r_ns) + END_W'(r_nl);
                n_i     = '0;
                n_o     = '0;
                n_hv    = 1'b0;
                n_atend = 1'b0;
                n_econs = 1'b0;
                n_state = S_PS_RD;
            end

            S_PS_RD: begin
                if (r_i == r_n) begin
                    n_atend = 1'b1;
                    n_state = r_ins ? S_PS_NCHK : S_PS_FLUSH;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = slot_addr(r_src, r_i[SLOT_W-1:0]);
                    n_state   = S_PS_GET;
                end
            end

            S_PS_GET: begin
                n_es = rd_s;
                n_el = rd_l;
                if (r_skip_en && r_i == r_skip) begin
                    n_i     = r_i + 1'b1;
                    n_state = S_PS_RD;
                end else if (r_ins && rd_s >= r_ns) begin
                    n_mnext = (r_nend == END_W'(rd_s));
                    n_state = S_PS_NMRG;
                end else begin
                    n_state = S_PS_EMIT_E;
                end
            end

            S_PS_NMRG: begin
                // merge the new range with the next one
                n_econs = r_mnext;
                if (r_mnext) begin
                    n_nl = sat_add(r_nl, r_el);
                end
                n_state = S_PS_NCHK;
            end

            S_PS_NCHK: begin
                n_pmerge = r_hv && (END_W'(r_hs) + END_W'(r_hl) == END_W'(r_ns));
                n_state  = S_PS_NEMIT;
            end

            S_PS_NEMIT: begin
                n_ins = 1'b0;
                if (r_pmerge) begin
                    n_hl = sat_add(r_hl, r_nl);
                end else begin
                    if (r_hv) begin
                        ram_we    = 1'b1;
                        ram_waddr = slot_addr(r_dst, r_o[SLOT_W-1:0]);
                        ram_wdata = {r_hs, r_hl};
                        n_o       = r_o + 1'b1;
                    end
                    n_hs = r_ns;
                    n_hl = r_nl;
                    n_hv = 1'b1;
                end
                if (r_atend) begin
                    n_state = S_PS_FLUSH;
                end else if (r_econs) begin
                    n_i     = r_i + 1'b1;
                    n_state = S_PS_RD;
                end else begin
                    n_state = S_PS_EMIT_E;
                end
            end

            S_PS_EMIT_E: begin
                if (r_hv) begin
                    ram_we    = 1'b1;
                    ram_waddr = slot_addr(r_dst, r_o[SLOT_W-1:0]);
                    ram_wdata = {r_hs, r_hl};
                    n_o       = r_o + 1'b1;
                end
                n_hs    = r_es;
                n_hl    = r_el;
                n_hv    = 1'b1;
                n_i     = r_i + 1'b1;
                n_state = S_PS_RD;
            end

            S_PS_FLUSH: begin
                if (r_hv) begin
                    ram_we    = 1'b1;
                    ram_waddr = slot_addr(r_dst, r_o[SLOT_W-1:0]);
                    ram_wdata = {r_hs, r_hl};
                    n_o       = r_o + 1'b1;
                end
                n_state = S_PS_END;
            end

            S_PS_END: begin
                if (!r_pass2 && r_rem_en) begin
                    // second pass: insert the remainder
                    n_pass2   = 1'b1;
                    n_src     = r_dst;
                    n_dst     = r_sp1;
                    n_n       = r_o;
                    n_skip_en = 1'b0;
                    n_ins     = 1'b1;
                    n_ns      = r_rem_s;
                    n_nl      = r_rem_l;
                    n_state   = S_PS_INIT;
                end else if (r_o > OCNT_W'(MAX_RANGES)) begin
                    n_rs_status = STATUS_LIST_FULL;
                    n_state     = S_FIN;
                end else begin
                    // commit: the rewritten row takes the block's place
                    n_ptr[bi] = r_dst;
                    n_cnt[bi] = CNT_W'(r_o);
                    if (r_dst == r_sp0) begin
                        n_sp0 = r_ptr[bi];
                    end else begin
                        n_sp1 = r_ptr[bi];
                    end
                    if (r_mode == MODE_ALLOC) begin
                        n_rs_blk   = bi;
                        n_rs_grant = r_grant;
                    end
                    n_state = S_FIN;
                end
            end

            S_NEW_FIND: begin
                if (nf_found) begin
                    n_blk   = BLK_CW'(nf_idx);
                    n_state = S_NEW_SZ;
                end else begin
                    n_rs_status = STATUS_NO_BLOCK;
                    n_state     = S_FIN;
                end
            end

            S_NEW_SZ: begin
                n_bsz   = (r_dflt > r_size) ? r_dflt : r_size;
                n_state = S_NEW_WR;
            end

            S_NEW_WR: begin
                n_used[bi] = 1'b1;
                n_type[bi] = r_mtype;
                n_blin[bi] = r_lreq;
                if (r_size < r_bsz) begin
                    ram_we    = 1'b1;
                    ram_waddr = slot_addr(r_ptr[bi], '0);
                    ram_wdata = {START_W'(r_size), r_bsz - r_size};
                    n_cnt[bi] = CNT_W'(1);
                end else begin
                    n_cnt[bi] = '0;
                end
                n_rs_blk = bi;
                n_rs_new = 1'b1;
                n_state  = S_FIN;
            end

            S_FIN: begin
                // hold until the output register is free
                if (!r_ov || !i_out_stall) begin
                    n_ov       = 1'b1;
                    n_o_status = r_rs_status;
                    n_o_blk    = OBLK_W'(r_rs_blk);
                    n_o_grant  = r_rs_grant;
                    n_o_new    = r_rs_new;
                    n_state    = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_dflt  <= DFLT_RESET;
            r_ov    <= 1'b0;
            r_sp0   <= ROW_W'(MAX_BLOCKS);
            r_sp1   <= ROW_W'(MAX_BLOCKS + 1);
            for (int k = 0; k < MAX_BLOCKS; k++) begin
                r_used[k] <= 1'b0;
                r_cnt[k]  <= '0;
                r_ptr[k]  <= ROW_W'(k);
            end
        end else begin
            r_state <= n_state;
            r_dflt  <= n_dflt;
            r_ov    <= n_ov;
            r_sp0   <= n_sp0;
            r_sp1   <= n_sp1;
            r_used  <= n_used;
            r_cnt   <= n_cnt;
            r_ptr   <= n_ptr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_type  <= n_type;   r_blin  <= n_blin;
        r_mode  <= n_mode;   r_mtype <= n_mtype; r_lreq <= n_lreq;
        r_size  <= n_size;   r_amask <= n_amask; r_blk  <= n_blk;  r_ri <= n_ri;
        r_off   <= n_off;    r_al    <= n_al;    r_end  <= n_end;  r_asz <= n_asz;
        r_grant <= n_grant;  r_rem_en <= n_rem_en; r_rem_s <= n_rem_s; r_rem_l <= n_rem_l;
        r_src   <= n_src;    r_dst   <= n_dst;   r_n    <= n_n;    r_skip <= n_skip;
        r_i     <= n_i;      r_o     <= n_o;     r_skip_en <= n_skip_en;
        r_ins   <= n_ins;    r_ns    <= n_ns;    r_nl   <= n_nl;   r_nend <= n_nend;
        r_es    <= n_es;     r_el    <= n_el;    r_mnext <= n_mnext;
        r_econs <= n_econs;  r_atend <= n_atend; r_hv   <= n_hv;   r_pmerge <= n_pmerge;
        r_pass2 <= n_pass2;  r_hs    <= n_hs;    r_hl   <= n_hl;   r_bsz <= n_bsz;
        r_rs_status <= n_rs_status; r_rs_blk <= n_rs_blk;
        r_rs_grant  <= n_rs_grant;  r_rs_new <= n_rs_new;
        r_o_status  <= n_o_status;  r_o_blk  <= n_o_blk;
        r_o_grant   <= n_o_grant;   r_o_new  <= n_o_new;
    end

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_cfg_ready    = 1'b1;
    assign o_out_valid    = r_ov;
    assign o_status       = r_o_status;
    assign o_grant_block  = r_o_blk;
    assign o_grant_offset = r_o_grant;
    assign o_new_block    = r_o_new;

    // ---- assertions ----
    a_spares_distinct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp0 != r_sp1)
        else $error("spare rows collide");

    for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_chk
        a_row_not_spare: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            r_used[g] |-> (r_ptr[g] != r_sp0 && r_ptr[g] != r_sp1))
            else $error("used block points at a spare row");
        a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            r_cnt[g] <= CNT_W'(MAX_RANGES))
            else $error("range count beyond list capacity");
    end

    a_pass_read_in_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PS_GET) |-> (r_i < r_n))
        else $error("pass read past end of source list");

endmodule
